@@ design/bme_pkg.sv @@
// ---------------------------------------------------------------------------
// bme_pkg - shared constants for the box mean image filter
// Sizes of the line store, counters and the sum/divide datapath.
// ---------------------------------------------------------------------------
`default_nettype none
package bme_pkg;
  localparam int MaxWidth   = 1024;
  localparam int MaxWindow  = 9;
  localparam int RingRows   = MaxWindow + 2;
  localparam int ColW       = $clog2(MaxWidth);      // column index bits
  localparam int SlotW      = $clog2(RingRows);      // ring row index bits
  localparam int DimW       = 11;                    // width/height register
  localparam int SizeW      = 4;                     // window size register
  localparam int CntW       = 2 * DimW;              // pixel counts in a frame
  localparam int SumW       = 15;                    // window total
  localparam int DivW       = 7;                     // size squared
  localparam int MemDepth   = RingRows * MaxWidth;
  localparam int AddrW      = SlotW + ColW;

  localparam logic [1:0] RegWidth  = 2'd0;
  localparam logic [1:0] RegHeight = 2'd1;
  localparam logic [1:0] RegSize   = 2'd2;
endpackage
`default_nettype wire

@@ design/bme_div.sv @@
// ---------------------------------------------------------------------------
// bme_div - restoring divider for the window total
// One quotient bit per cycle; quotient saturated to 8 bits.
// ---------------------------------------------------------------------------
`default_nettype none
module bme_div (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    start,
  input  wire logic [bme_pkg::SumW-1:0] dividend,
  input  wire logic [bme_pkg::DivW-1:0] divisor,
  output logic                         done,
  output logic [7:0]                   quotient
);
  import bme_pkg::*;

  logic [SumW-1:0]  quo;
  logic [DivW:0]    rem;
  logic [3:0]       steps;
  logic             busy;
  logic [DivW:0]    rem_shift;
  logic [DivW:0]    div_ext;

  assign div_ext   = {1'b0, divisor};
  assign rem_shift = {rem[DivW-1:0], quo[SumW-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      steps <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        steps <= 4'(SumW);
      end else if (busy) begin
        steps <= steps - 4'd1;
        if (steps == 4'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
    end else if (busy) begin
      if (rem_shift >= div_ext) begin
        rem <= rem_shift - div_ext;
        quo <= {quo[SumW-2:0], 1'b1};
      end else begin
        rem <= rem_shift;
        quo <= {quo[SumW-2:0], 1'b0};
      end
    end
  end

  assign quotient = (quo > SumW'(255)) ? 8'hFF : quo[7:0];
endmodule
`default_nettype wire

@@ design/box_mean_image_filter.sv @@
// ---------------------------------------------------------------------------
// box_mean_image_filter - streaming box mean filter for 8-bit gray images
// Line-store based window sum with a serial divider.
// ---------------------------------------------------------------------------
// Pixels enter in raster order on the slave stream (tuser = 1 marks a flush
// item, sent after the last pixel to push out the trailing rows). Each pixel
// is written into a ring of RingRows line buffers. Once enough pixels have
// arrived, the window around the next output position is summed one pixel per
// cycle through the registered line-store read port, then divided by size
// squared in a 15-step restoring divider and saturated to 255. An item that
// produces a result passes through accept, window sweep, a drain state, the
// divider, a wait state that holds until the output register is free, and an
// output state. The result sits in an output register, so the next item may be
// accepted while it waits; a following result holds the input off until that
// register drains. Pixels outside the image count as zero. A write to the
// width, height or size register restarts the frame. tlast marks the final
// filtered pixel of the frame, after which a new frame starts.
// ---------------------------------------------------------------------------
`default_nettype none
module box_mean_image_filter (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_wen,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [10:0] cfg_data,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] pixel_in
  input  wire logic        s_axis_tuser,   // action
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [7:0]       m_axis_tdata,   // [7:0] pixel_out
  output logic             m_axis_tlast    // frame_end
);
  import bme_pkg::*;

  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StSum   = 3'd1;
  localparam logic [2:0] StDrain = 3'd2;
  localparam logic [2:0] StDiv   = 3'd3;
  localparam logic [2:0] StWait  = 3'd4;
  localparam logic [2:0] StOut   = 3'd5;

  // configuration
  logic [DimW-1:0]  image_width, image_height;
  logic [SizeW-1:0] window_size;
  logic [DimW-1:0]  w_eff, h_eff;
  logic [SizeW-1:0] s_eff;
  logic [2:0]       half;
  logic [CntW-1:0]  total, lag;
  logic [DivW-1:0]  sq;

  always_comb begin
    w_eff = (image_width == '0) ? DimW'(1) :
            (image_width > DimW'(MaxWidth)) ? DimW'(MaxWidth) : image_width;
    h_eff = (image_height == '0) ? DimW'(1) : image_height;
    s_eff = (window_size == '0) ? SizeW'(1) :
            (window_size > SizeW'(MaxWindow)) ? SizeW'(MaxWindow) : window_size;
    half  = s_eff[3:1];
    total = CntW'(w_eff) * CntW'(h_eff);
    lag   = CntW'(half) * CntW'(w_eff) + CntW'(half);
    sq    = DivW'(s_eff) * DivW'(s_eff);
  end

  // counters
  logic [DimW-1:0]  in_col, in_row, out_col, out_row;
  logic [SlotW-1:0] in_slot, out_slot;
  logic [CntW-1:0]  rcv_cnt, prod_cnt;
  logic [2:0]       state;
  logic [3:0]       ir, ic;
  logic [SumW-1:0]  acc;
  logic             rd_valid;
  logic [7:0]       rdata;
  logic             div_start, div_done;
  logic [7:0]       quotient;

  logic accept, is_flush, pix_take, pix_emit, flush_emit, frame_last;
  assign s_axis_tready = (state == StIdle);
  assign accept   = s_axis_tvalid && s_axis_tready;
  assign is_flush = s_axis_tuser;
  assign pix_take   = accept && !is_flush && (rcv_cnt < total);
  assign pix_emit   = pix_take && ((rcv_cnt + CntW'(1)) > (prod_cnt + lag));
  assign flush_emit = accept && is_flush && (rcv_cnt >= total) && (prod_cnt < total);
  assign frame_last = (prod_cnt == total - CntW'(1));

  // window address generation
  logic [DimW:0]    rt, ct;
  logic             rd_ok;
  logic [5:0]       st0, st1, st2;
  logic [SlotW-1:0] rslot;
  logic [ColW-1:0]  rcol;
  logic [3:0]       span;

  always_comb begin
    span  = {half, 1'b0};
    rt    = {1'b0, out_row} + (DimW+1)'(ir);
    ct    = {1'b0, out_col} + (DimW+1)'(ic);
    rd_ok = (rt >= (DimW+1)'(half)) && ((rt - (DimW+1)'(half)) < {1'b0, h_eff}) &&
            (ct >= (DimW+1)'(half)) && ((ct - (DimW+1)'(half)) < {1'b0, w_eff});
    st0   = 6'(out_slot) + 6'(ir) + 6'(RingRows) - 6'(half);
    st1   = (st0 >= 6'(RingRows)) ? st0 - 6'(RingRows) : st0;
    st2   = (st1 >= 6'(RingRows)) ? st1 - 6'(RingRows) : st1;
    rslot = st2[SlotW-1:0];
    rcol  = ColW'(ct - (DimW+1)'(half));
  end

  // line store
  logic [7:0] line_store [0:MemDepth-1];
  always_ff @(posedge clk) begin
    if (pix_take) begin
      line_store[{in_slot, in_col[ColW-1:0]}] <= s_axis_tdata;
    end
    rdata <= line_store[{rslot, rcol}];
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width   <= DimW'(512);
      image_height  <= DimW'(512);
      window_size   <= SizeW'(9);
      in_col <= '0; in_row <= '0; in_slot <= '0; rcv_cnt <= '0;
      out_col <= '0; out_row <= '0; out_slot <= '0; prod_cnt <= '0;
      state         <= StIdle;
      ir <= '0; ic <= '0;
      rd_valid      <= 1'b0;
      m_axis_tvalid <= 1'b0;
      div_start     <= 1'b0;
    end else begin
      div_start <= 1'b0;
      rd_valid  <= (state == StSum) && rd_ok;
      if (m_axis_tvalid && m_axis_tready) m_axis_tvalid <= 1'b0;

      if (cfg_wen) begin
        unique case (cfg_index)
          RegWidth:  image_width  <= cfg_data;
          RegHeight: image_height <= cfg_data;
          RegSize:   window_size  <= cfg_data[SizeW-1:0];
          default: ;
        endcase
        if (cfg_index == RegWidth || cfg_index == RegHeight || cfg_index == RegSize) begin
          in_col <= '0; in_row <= '0; in_slot <= '0; rcv_cnt <= '0;
          out_col <= '0; out_row <= '0; out_slot <= '0; prod_cnt <= '0;
        end
      end

      unique case (state)
        StIdle: begin
          if (pix_take) begin
            rcv_cnt <= rcv_cnt + CntW'(1);
            if (in_col + DimW'(1) >= w_eff) begin
              in_col  <= '0;
              in_row  <= in_row + DimW'(1);
              in_slot <= (in_slot == SlotW'(RingRows - 1)) ? '0 : in_slot + SlotW'(1);
            end else begin
              in_col <= in_col + DimW'(1);
            end
          end
          if (pix_emit || flush_emit) begin
            state <= StSum;
            ir <= '0; ic <= '0;
          end
        end
        StSum: begin
          if (ic == span) begin
            ic <= '0;
            if (ir == span) state <= StDrain;
            else ir <= ir + 4'd1;
          end else begin
            ic <= ic + 4'd1;
          end
        end
        StDrain: begin
          state     <= StDiv;
          div_start <= 1'b1;
        end
        StDiv: begin
          if (div_done) state <= StWait;
        end
        StWait: begin
          if (!m_axis_tvalid || m_axis_tready) state <= StOut;
        end
        StOut: begin
          m_axis_tvalid <= 1'b1;
          state         <= StIdle;
          if (frame_last) begin
            in_col <= '0; in_row <= '0; in_slot <= '0; rcv_cnt <= '0;
            out_col <= '0; out_row <= '0; out_slot <= '0; prod_cnt <= '0;
          end else begin
            prod_cnt <= prod_cnt + CntW'(1);
            if (out_col + DimW'(1) >= w_eff) begin
              out_col  <= '0;
              out_row  <= out_row + DimW'(1);
              out_slot <= (out_slot == SlotW'(RingRows - 1)) ? '0 : out_slot + SlotW'(1);
            end else begin
              out_col <= out_col + DimW'(1);
            end
          end
        end
        default: state <= StIdle;
      endcase
    end
  end

  // window accumulator and output payload
  always_ff @(posedge clk) begin
    if (state == StIdle) acc <= '0;
    else if (rd_valid) acc <= acc + SumW'(rdata);
    if (state == StOut) begin
      m_axis_tdata <= quotient;
      m_axis_tlast <= frame_last;
    end
  end

  bme_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (acc),
    .divisor  (sq),
    .done     (div_done),
    .quotient (quotient)
  );
endmodule
`default_nettype wire
